[design/tcfp_pkg.sv]
// ----------------------------------------------------------------------------
// tcfp_pkg
// Shared types, codes and character constants of the text command line parser.
// ----------------------------------------------------------------------------
package tcfp_pkg;

	// Configuration register indexes
	typedef enum logic [1:0] {
		CFG_HEADER_TEXT      = 2'd0,
		CFG_HEADER_LENGTH    = 2'd1,
		CFG_DEVICE_ID_TEXT   = 2'd2,
		CFG_DEVICE_ID_LENGTH = 2'd3
	} cfg_reg_t;

	// Line classification codes
	typedef enum logic [2:0] {
		ST_START      = 3'd0,
		ST_STOP       = 3'd1,
		ST_OTHER_CMD  = 3'd2,
		ST_DATA       = 3'd3,
		ST_OTHER_TYPE = 3'd4,
		ST_WRONG_DEV  = 3'd5,
		ST_MALFORMED  = 3'd6,
		ST_OVERFLOW   = 3'd7
	} line_status_t;

	// Running parse state of the line in progress
	typedef struct packed {
		logic [7:0] byte_count;
		logic [1:0] field_number;
		logic [7:0] field_position;
		logic       header_match;
		logic       id_match;
		logic [1:0] type_flags;     // bit 0 CMD, bit 1 DATA
		logic [1:0] content_flags;  // bit 0 START, bit 1 STOP
		logic       zero_byte_seen;
	} line_state_t;

	localparam line_state_t LINE_CLEAR = '{
		byte_count:     8'd0,
		field_number:   2'd0,
		field_position: 8'd0,
		header_match:   1'b1,
		id_match:       1'b1,
		type_flags:     2'b11,
		content_flags:  2'b11,
		zero_byte_seen: 1'b0
	};

	localparam logic [7:0] CH_NUL   = 8'h00;
	localparam logic [7:0] CH_LF    = 8'h0A;
	localparam logic [7:0] CH_CR    = 8'h0D;
	localparam logic [7:0] CH_COMMA = 8'h2C;

	localparam logic [63:0] HEADER_TEXT_RESET = 64'd280553802788;
	localparam logic [3:0]  HEADER_LEN_RESET  = 4'd5;

	localparam logic [1:0] FIELD_ID      = 2'd1;
	localparam logic [1:0] FIELD_TYPE    = 2'd2;
	localparam logic [1:0] FIELD_CONTENT = 2'd3;

	// Limit a configured length to the eight characters a register holds
	function automatic logic [3:0] clamp_len(input logic [3:0] len);
		return (len > 4'd8) ? 4'd8 : len;
	endfunction

	function automatic logic cmd_has(input logic [7:0] pos, input logic [7:0] c);
		logic hit;
		case (pos)
			8'd0:    hit = (c == "C");
			8'd1:    hit = (c == "M");
			8'd2:    hit = (c == "D");
			default: hit = 1'b0;
		endcase
		return hit;
	endfunction

	function automatic logic data_has(input logic [7:0] pos, input logic [7:0] c);
		logic hit;
		case (pos)
			8'd0:    hit = (c == "D");
			8'd1:    hit = (c == "A");
			8'd2:    hit = (c == "T");
			8'd3:    hit = (c == "A");
			default: hit = 1'b0;
		endcase
		return hit;
	endfunction

	function automatic logic start_has(input logic [7:0] pos, input logic [7:0] c);
		logic hit;
		case (pos)
			8'd0:    hit = (c == "S");
			8'd1:    hit = (c == "T");
			8'd2:    hit = (c == "A");
			8'd3:    hit = (c == "R");
			8'd4:    hit = (c == "T");
			default: hit = 1'b0;
		endcase
		return hit;
	endfunction

	function automatic logic stop_has(input logic [7:0] pos, input logic [7:0] c);
		logic hit;
		case (pos)
			8'd0:    hit = (c == "S");
			8'd1:    hit = (c == "T");
			8'd2:    hit = (c == "O");
			8'd3:    hit = (c == "P");
			default: hit = 1'b0;
		endcase
		return hit;
	endfunction

endpackage

[design/tcfp_classify.sv]
// ----------------------------------------------------------------------------
// tcfp_classify
// Classifies a finished line from its running parse state.
// ----------------------------------------------------------------------------
module tcfp_classify (
	input  tcfp_pkg::line_state_t  st,
	input  logic [3:0]             header_len,
	output tcfp_pkg::line_status_t status
);
	import tcfp_pkg::*;

	always_comb begin
		if (!st.header_match || (st.byte_count < {4'd0, header_len})
				|| (st.field_number != FIELD_CONTENT)) begin
			status = ST_MALFORMED;
		end else if (!st.id_match) begin
			status = ST_WRONG_DEV;
		end else if (st.type_flags[0]) begin
			if (st.content_flags[0] && (st.field_position == 8'd5)) begin
				status = ST_START;
			end else if (st.content_flags[1] && (st.field_position == 8'd4)) begin
				status = ST_STOP;
			end else begin
				status = ST_OTHER_CMD;
			end
		end else if (st.type_flags[1]) begin
			status = ST_DATA;
		end else begin
			status = ST_OTHER_TYPE;
		end
	end

endmodule

[design/text_command_frame_parser.sv]
// ----------------------------------------------------------------------------
// text_command_frame_parser
// Streaming parser that classifies comma separated text command lines.
// ----------------------------------------------------------------------------
// Takes one received byte per clock, unless in_stall holds it off, and emits
// one result per non-empty line, when the CR or LF that ends it arrives, or at
// once when a line outgrows the buffer (status overflow, the offending byte
// discarded). A byte passes through an input register. At the first edge at
// which the result register is free or draining it is folded into the line
// state, and when it ends or drops a line the output register loads at that
// same edge. Throughput is one byte per clock while no stalled result blocks
// it, set by the single state update between the input and result registers.
// in_stall rises only while a byte waits in the input register behind a result
// that out_stall holds in the output register. Configuration is taken on every
// cycle (cfg_ready is tied high) and must be written while no line is in
// progress.
// ----------------------------------------------------------------------------
module text_command_frame_parser #(
	parameter int LINE_BUFFER_SIZE = 256
) (
	input  logic        clk,
	input  logic        arst_n,
	// byte input channel
	input  logic        in_valid,
	output logic        in_stall,
	input  logic [7:0]  rx_byte,
	// result channel
	output logic        out_valid,
	input  logic        out_stall,
	output logic [2:0]  line_status,
	output logic [7:0]  line_length,
	// configuration write channel
	input  logic        cfg_valid,
	output logic        cfg_ready,
	input  logic [1:0]  cfg_index,
	input  logic [63:0] cfg_data
);
	import tcfp_pkg::*;

	// A byte arriving at this count drops the line
	localparam logic [7:0] OVF_LIMIT = 8'(LINE_BUFFER_SIZE - 1);

	// Configuration registers
	logic [63:0] header_text_q;
	logic [3:0]  header_length_q;
	logic [63:0] device_id_text_q;
	logic [3:0]  device_id_length_q;

	// Input register
	logic        valid_s1;
	logic [7:0]  byte_s1;

	// Line state and result register
	line_state_t st_q, st_nxt;
	logic        out_valid_q;
	logic [2:0]  status_q;
	logic [7:0]  length_q;

	logic         advance;
	logic         res_fire;
	line_status_t res_status;
	line_status_t cls_status;
	logic [3:0]   hl, il;
	logic [7:0]   hdr_char, id_char;

	assign cfg_ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			header_text_q      <= HEADER_TEXT_RESET;
			header_length_q    <= HEADER_LEN_RESET;
			device_id_text_q   <= '0;
			device_id_length_q <= '0;
		end else if (cfg_valid && cfg_ready) begin
			case (cfg_reg_t'(cfg_index))
				CFG_HEADER_TEXT:      header_text_q      <= cfg_data;
				CFG_HEADER_LENGTH:    header_length_q    <= cfg_data[3:0];
				CFG_DEVICE_ID_TEXT:   device_id_text_q   <= cfg_data;
				CFG_DEVICE_ID_LENGTH: device_id_length_q <= cfg_data[3:0];
				default: ;
			endcase
		end
	end

	// Advance the held byte whenever the result register is free or draining
	assign advance  = valid_s1 && (!out_valid_q || !out_stall);
	assign in_stall = valid_s1 && !advance;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (in_valid && !in_stall) begin
			valid_s1 <= 1'b1;
		end else if (advance) begin
			valid_s1 <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (in_valid && !in_stall) begin
			byte_s1 <= rx_byte;
		end
	end

	assign hl = clamp_len(header_length_q);
	assign il = clamp_len(device_id_length_q);

	// Only the low three bits matter: each lookup is guarded by a length of at most eight
	assign hdr_char = header_text_q[{st_q.byte_count[2:0], 3'b000} +: 8];
	assign id_char  = device_id_text_q[{st_q.field_position[2:0], 3'b000} +: 8];

	tcfp_classify u_classify (
		.st         (st_q),
		.header_len (hl),
		.status     (cls_status)
	);

	// Fold the held byte into the line state
	always_comb begin
		st_nxt     = st_q;
		res_fire   = 1'b0;
		res_status = ST_OVERFLOW;
		if (advance) begin
			if (st_q.byte_count >= OVF_LIMIT) begin
				// drop the line, the byte goes with it
				res_fire = 1'b1;
				st_nxt   = LINE_CLEAR;
			end else if ((byte_s1 == CH_LF) || (byte_s1 == CH_CR)) begin
				// empty lines give nothing
				if (st_q.byte_count != 8'd0) begin
					res_fire   = 1'b1;
					res_status = cls_status;
					st_nxt     = LINE_CLEAR;
				end
			end else begin
				st_nxt.byte_count = st_q.byte_count + 8'd1;
				if (!st_q.zero_byte_seen) begin
					if (byte_s1 == CH_NUL) begin
						// freeze matching for the rest of the line
						st_nxt.zero_byte_seen = 1'b1;
						if (st_q.byte_count < {4'd0, hl}) begin
							st_nxt.header_match = 1'b0;
						end
					end else begin
						if ((st_q.byte_count < {4'd0, hl}) && (hdr_char != byte_s1)) begin
							st_nxt.header_match = 1'b0;
						end
						if ((byte_s1 == CH_COMMA) && (st_q.field_number != FIELD_CONTENT)) begin
							// close the field and check its length
							if ((st_q.field_number == FIELD_ID)
									&& (st_q.field_position != {4'd0, il})) begin
								st_nxt.id_match = 1'b0;
							end
							if (st_q.field_number == FIELD_TYPE) begin
								if (st_q.field_position != 8'd3) begin
									st_nxt.type_flags[0] = 1'b0;
								end
								if (st_q.field_position != 8'd4) begin
									st_nxt.type_flags[1] = 1'b0;
								end
							end
							st_nxt.field_number   = st_q.field_number + 2'd1;
							st_nxt.field_position = 8'd0;
						end else begin
							case (st_q.field_number)
								FIELD_ID: begin
									if (!((st_q.field_position < {4'd0, il})
											&& (id_char == byte_s1))) begin
										st_nxt.id_match = 1'b0;
									end
								end
								FIELD_TYPE: begin
									if (!cmd_has(st_q.field_position, byte_s1)) begin
										st_nxt.type_flags[0] = 1'b0;
									end
									if (!data_has(st_q.field_position, byte_s1)) begin
										st_nxt.type_flags[1] = 1'b0;
									end
								end
								FIELD_CONTENT: begin
									if (!start_has(st_q.field_position, byte_s1)) begin
										st_nxt.content_flags[0] = 1'b0;
									end
									if (!stop_has(st_q.field_position, byte_s1)) begin
										st_nxt.content_flags[1] = 1'b0;
									end
								end
								default: ;
							endcase
							// saturate the position count
							if (st_q.field_position != 8'hFF) begin
								st_nxt.field_position = st_q.field_position + 8'd1;
							end
						end
					end
				end
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			st_q <= LINE_CLEAR;
		end else begin
			st_q <= st_nxt;
		end
	end

	// Result register: load on a finished line, drop once the transaction completes
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (res_fire) begin
			out_valid_q <= 1'b1;
		end else if (!out_stall) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (res_fire) begin
			status_q <= res_status;
			length_q <= st_q.byte_count;
		end
	end

	assign out_valid   = out_valid_q;
	assign line_status = status_q;
	assign line_length = length_q;

endmodule

[design/tcfp_checker.sv]
// ----------------------------------------------------------------------------
// tcfp_checker
// Port level checks of the text command line parser, bound to the top level.
// ----------------------------------------------------------------------------
module tcfp_checker #(
	parameter int LINE_BUFFER_SIZE = 256
) (
	input logic       clk,
	input logic       arst_n,
	input logic       in_stall,
	input logic       out_valid,
	input logic       out_stall,
	input logic [2:0] line_status,
	input logic [7:0] line_length
);
	import tcfp_pkg::*;

	localparam logic [7:0] OVF_LIMIT = 8'(LINE_BUFFER_SIZE - 1);

	// a stalled result holds
	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && out_stall |=> out_valid && $stable(line_status) && $stable(line_length))
		else $error("result changed while stalled");

	// input back-pressure only comes from a blocked result
	a_stall_cause: assert property (@(posedge clk) disable iff (!arst_n)
		in_stall |-> out_valid && out_stall)
		else $error("input stalled without a blocked result");

	// a dropped line is always full
	a_ovf_len: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && (line_status == ST_OVERFLOW) |-> line_length == OVF_LIMIT)
		else $error("overflow with wrong length");

	// a classified line is non-empty and shorter than the buffer
	a_line_len: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && (line_status != ST_OVERFLOW)
			|-> (line_length != 8'd0) && (line_length < OVF_LIMIT))
		else $error("classified line length out of range");

endmodule

bind text_command_frame_parser tcfp_checker #(
	.LINE_BUFFER_SIZE (LINE_BUFFER_SIZE)
) u_tcfp_checker (
	.clk         (clk),
	.arst_n      (arst_n),
	.in_stall    (in_stall),
	.out_valid   (out_valid),
	.out_stall   (out_stall),
	.line_status (line_status),
	.line_length (line_length)
);

[verif/tb.sv]
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb
// Self-checking bench for the text command line parser.
// ----------------------------------------------------------------------------
// Feeds received bytes into the parser, one transaction per byte. A bench-side
// line tracker works out the classification of every finished or dropped
// line. Each result transaction is checked against the oldest outstanding
// expectation. A short table of hand-made lines comes first: every status
// code, blank lines, zero bytes, overflow and the extreme byte values. After
// it come random phases under several register settings: mostly well-formed
// lines with random content, plus noise, broken lines and the odd overlong
// line. Both sides insert idle cycles and stalls at random.
// ----------------------------------------------------------------------------
module tb;
	import tcfp_pkg::*;

	localparam int LINE_BUF        = 256;
	localparam int RESET_CYCLES    = 7;
	localparam int SETTLE_CYCLES   = 6;      // pipeline is two deep, allow slack
	localparam int RAND_PHASES     = 6;
	localparam int RAND_BYTES      = 160;    // per phase
	localparam int LONG_HOLD       = 200;
	localparam int RUN_LIMIT_NS    = 2_000_000;

	// Flag bits of the running line state
	localparam int CMD_BIT   = 0;
	localparam int DATA_BIT  = 1;
	localparam int START_BIT = 0;
	localparam int STOP_BIT  = 1;

	// Keywords, right-justified, first character in the highest used byte
	localparam logic [39:0] KW_CMD   = "CMD";
	localparam logic [39:0] KW_DATA  = "DATA";
	localparam logic [39:0] KW_START = "START";
	localparam logic [39:0] KW_STOP  = "STOP";

	typedef struct packed {
		line_status_t status;
		logic [7:0]   length;
	} line_result_t;

	// One hand-made line: text, then fill_count copies of fill, then term.
	// Where pinned is set the status is known by inspection.
	typedef struct {
		string        text;
		logic [7:0]   fill;
		int           fill_count;
		logic [7:0]   term;
		bit           pinned;
		line_status_t status;
	} probe_line_t;

	localparam int N_PROBES = 20;

	// All of these run under the register values left by reset
	probe_line_t probes [N_PROBES] = '{
		'{"$LORA,,CMD,START",        CH_NUL,   0, CH_LF, 1'b1, ST_START},
		'{"$LORA,,CMD,STOP",         CH_NUL,   0, CH_CR, 1'b1, ST_STOP},
		'{"$LORA,,CMD,GO",           CH_NUL,   0, CH_LF, 1'b1, ST_OTHER_CMD},
		'{"$LORA,,CMD,START,X",      CH_NUL,   0, CH_LF, 1'b0, ST_START},
		'{"$LORA,,DATA,hello,world", CH_NUL,   0, CH_CR, 1'b1, ST_DATA},
		'{"$LORA,,PING,x",           CH_NUL,   0, CH_LF, 1'b1, ST_OTHER_TYPE},
		'{"$LORA,X,CMD,START",       CH_NUL,   0, CH_LF, 1'b1, ST_WRONG_DEV},
		'{"$LOR",                    CH_NUL,   0, CH_LF, 1'b1, ST_MALFORMED},
		'{"#LORA,,CMD,START",        CH_NUL,   0, CH_CR, 1'b1, ST_MALFORMED},
		'{"$LORA,,CMD",              CH_NUL,   0, CH_LF, 1'b1, ST_MALFORMED},
		'{"$LORB,X,CMD,START",       CH_NUL,   0, CH_LF, 1'b1, ST_MALFORMED},
		'{"",                        CH_NUL,   0, CH_LF, 1'b0, ST_START},
		'{"$LORA,,CMD,START",        CH_NUL,   3, CH_LF, 1'b1, ST_START},
		'{"$LO",                     CH_NUL,   1, CH_CR, 1'b1, ST_MALFORMED},
		'{"",                        8'hFF,  255, CH_LF, 1'b1, ST_OVERFLOW},
		'{"$LORA,,DATA,",            8'hFF,    2, CH_LF, 1'b1, ST_DATA},
		'{"$LORA,,CMD,STARTX",       CH_NUL,   0, CH_CR, 1'b1, ST_OTHER_CMD},
		'{"$LORA,,cmd,START",        CH_NUL,   0, CH_LF, 1'b1, ST_OTHER_TYPE},
		'{"$LORA,,CMD,",             CH_NUL,   0, CH_LF, 1'b0, ST_START},
		'{"$LORA",                   CH_NUL,   0, CH_CR, 1'b1, ST_MALFORMED}
	};

	// ------------------------------------------------------------------------
	// Clock, reset and DUT
	// ------------------------------------------------------------------------
	logic        clk       = 1'b0;
	logic        arst_n    = 1'b0;
	logic        in_valid  = 1'b0;
	logic        in_stall;
	logic [7:0]  rx_byte   = 8'd0;
	logic        out_valid;
	logic        out_stall = 1'b0;
	logic [2:0]  line_status;
	logic [7:0]  line_length;
	logic        cfg_valid = 1'b0;
	logic        cfg_ready;
	logic [1:0]  cfg_index = CFG_HEADER_TEXT;
	logic [63:0] cfg_data  = 64'd0;

	always #5 clk = ~clk;

	text_command_frame_parser #(
		.LINE_BUFFER_SIZE(LINE_BUF)
	) u_dut (
		.clk         (clk),
		.arst_n      (arst_n),
		.in_valid    (in_valid),
		.in_stall    (in_stall),
		.rx_byte     (rx_byte),
		.out_valid   (out_valid),
		.out_stall   (out_stall),
		.line_status (line_status),
		.line_length (line_length),
		.cfg_valid   (cfg_valid),
		.cfg_ready   (cfg_ready),
		.cfg_index   (cfg_index),
		.cfg_data    (cfg_data)
	);

	// ------------------------------------------------------------------------
	// Bench-side copy of the registers and of the line being parsed
	// ------------------------------------------------------------------------
	logic [63:0]  cfg_hdr_text = HEADER_TEXT_RESET;
	logic [3:0]   cfg_hdr_len  = HEADER_LEN_RESET;
	logic [63:0]  cfg_id_text  = 64'd0;
	logic [3:0]   cfg_id_len   = 4'd0;
	line_state_t  cur_line     = LINE_CLEAR;

	line_result_t lines_due [$];    // classifications still owed by the DUT
	logic [7:0]   line_bytes [$];   // random line under construction

	int mismatches;
	int bytes_sent;
	int src_idle_pct;
	int sink_idle_pct;
	int hold_reqs;                  // bumped by the stimulus to ask for a long hold

	// Lengths above eight still only cover the eight characters a register holds
	function automatic int chars_used(input logic [3:0] n);
		return (n > 4'd8) ? 8 : int'(n);
	endfunction

	// Characters are packed low byte first
	function automatic logic [7:0] text_char(input logic [63:0] txt, input int idx);
		return txt[8 * (idx & 7) +: 8];
	endfunction

	function automatic bit word_char(input logic [39:0] word, input int wlen, input int idx,
			input logic [7:0] c);
		if (idx >= wlen)
			return 1'b0;
		return word[8 * (wlen - 1 - idx) +: 8] == c;
	endfunction

	// Fold one ordinary byte (not CR/LF) into the running line state
	function automatic void fold_byte(input logic [7:0] c);
		int at;
		int hl;
		int il;
		int fp;
		at = cur_line.byte_count;
		hl = chars_used(cfg_hdr_len);
		il = chars_used(cfg_id_len);
		fp = cur_line.field_position;
		cur_line.byte_count = cur_line.byte_count + 8'd1;
		// Everything after a zero byte only counts towards the length
		if (cur_line.zero_byte_seen)
			return;
		if (c == CH_NUL) begin
			cur_line.zero_byte_seen = 1'b1;
			if (at < hl)
				cur_line.header_match = 1'b0;
			return;
		end
		if (at < hl && text_char(cfg_hdr_text, at) != c)
			cur_line.header_match = 1'b0;
		// Commas split the first three fields; the content keeps any further ones
		if (c == CH_COMMA && cur_line.field_number < FIELD_CONTENT) begin
			if (cur_line.field_number == FIELD_ID && fp != il)
				cur_line.id_match = 1'b0;
			if (cur_line.field_number == FIELD_TYPE) begin
				if (fp != 3)
					cur_line.type_flags[CMD_BIT] = 1'b0;
				if (fp != 4)
					cur_line.type_flags[DATA_BIT] = 1'b0;
			end
			cur_line.field_number   = cur_line.field_number + 2'd1;
			cur_line.field_position = 8'd0;
			return;
		end
		case (cur_line.field_number)
			FIELD_ID: begin
				if (!(fp < il && text_char(cfg_id_text, fp) == c))
					cur_line.id_match = 1'b0;
			end
			FIELD_TYPE: begin
				if (!word_char(KW_CMD, 3, fp, c))
					cur_line.type_flags[CMD_BIT] = 1'b0;
				if (!word_char(KW_DATA, 4, fp, c))
					cur_line.type_flags[DATA_BIT] = 1'b0;
			end
			FIELD_CONTENT: begin
				if (!word_char(KW_START, 5, fp, c))
					cur_line.content_flags[START_BIT] = 1'b0;
				if (!word_char(KW_STOP, 4, fp, c))
					cur_line.content_flags[STOP_BIT] = 1'b0;
			end
			default: ;
		endcase
		if (fp < 255)
			cur_line.field_position = 8'(fp + 1);
	endfunction

	function automatic line_status_t classify_line();
		if (!cur_line.header_match || cur_line.byte_count < chars_used(cfg_hdr_len) ||
				cur_line.field_number < FIELD_CONTENT)
			return ST_MALFORMED;
		if (!cur_line.id_match)
			return ST_WRONG_DEV;
		if (cur_line.type_flags[CMD_BIT]) begin
			if (cur_line.content_flags[START_BIT] && cur_line.field_position == 8'd5)
				return ST_START;
			if (cur_line.content_flags[STOP_BIT] && cur_line.field_position == 8'd4)
				return ST_STOP;
			return ST_OTHER_CMD;
		end
		if (cur_line.type_flags[DATA_BIT])
			return ST_DATA;
		return ST_OTHER_TYPE;
	endfunction

	// Advance the line tracker by one accepted byte; returns 1 when a line result is due
	function automatic bit track_rx_byte(input logic [7:0] c, output line_result_t res);
		res = '{status: ST_MALFORMED, length: 8'd0};
		// A full buffer drops the line and discards the byte, whatever it is
		if (cur_line.byte_count >= LINE_BUF - 1) begin
			res.status = ST_OVERFLOW;
			res.length = cur_line.byte_count;
			cur_line   = LINE_CLEAR;
			return 1'b1;
		end
		if (c == CH_LF || c == CH_CR) begin
			if (cur_line.byte_count == 8'd0)
				return 1'b0;    // blank line: nothing to report
			res.status = classify_line();
			res.length = cur_line.byte_count;
			cur_line   = LINE_CLEAR;
			return 1'b1;
		end
		fold_byte(c);
		return 1'b0;
	endfunction

	// ------------------------------------------------------------------------
	// Checking
	// ------------------------------------------------------------------------
	task automatic flag_mismatch(input string what);
		$display("[%0t] MISMATCH: %s", $time, what);
		mismatches++;
	endtask

	task automatic check_line_result();
		line_result_t owed;
		if (lines_due.size() == 0) begin
			flag_mismatch($sformatf("unexpected result status %0d length %0d",
				line_status, line_length));
			return;
		end
		owed = lines_due.pop_front();
		if (line_status !== owed.status)
			flag_mismatch($sformatf("line_status %0d, expected %0d (length %0d)",
				line_status, owed.status, owed.length));
		if (line_length !== owed.length)
			flag_mismatch($sformatf("line_length %0d, expected %0d", line_length,
				owed.length));
	endtask

	// Result side: sample the transaction of the edge just gone, then decide
	// whether to stall for the next one. Long holds are counted here.
	initial begin : result_sink
		int hold_left;
		int hold_taken;
		hold_left  = 0;
		hold_taken = 0;
		forever begin
			@(posedge clk);
			if (out_valid && !out_stall)
				check_line_result();
			if (hold_reqs != hold_taken) begin
				hold_taken = hold_reqs;
				hold_left  = LONG_HOLD;
			end
			if (hold_left > 0) begin
				out_stall <= 1'b1;
				hold_left--;
			end else begin
				out_stall <= ($urandom_range(99) < sink_idle_pct);
			end
		end
	end

	// ------------------------------------------------------------------------
	// Stimulus helpers
	// ------------------------------------------------------------------------
	// Offer one byte; returns just after the edge that took the transaction
	task automatic send_byte(input logic [7:0] c, input bit pinned,
			input line_status_t pin_status);
		line_result_t res;
		while ($urandom_range(99) < src_idle_pct) begin
			in_valid <= 1'b0;
			@(posedge clk);
		end
		in_valid <= 1'b1;
		rx_byte  <= c;
		@(posedge clk);
		while (in_stall)
			@(posedge clk);
		if (track_rx_byte(c, res)) begin
			if (pinned)
				res.status = pin_status;
			lines_due.push_back(res);
		end
		bytes_sent++;
	endtask

	// Drop valid and hold until every owed result has come back
	task automatic wait_drained();
		in_valid <= 1'b0;
		@(posedge clk);
		while (lines_due.size() != 0)
			@(posedge clk);
	endtask

	// Leaves cfg_valid high; the caller lowers it after the last register
	task automatic write_reg(input cfg_reg_t idx, input logic [63:0] val);
		cfg_valid <= 1'b1;
		cfg_index <= idx;
		cfg_data  <= val;
		@(posedge clk);
		while (!cfg_ready)
			@(posedge clk);
		case (idx)
			CFG_HEADER_TEXT:    cfg_hdr_text = val;
			CFG_HEADER_LENGTH:  cfg_hdr_len  = val[3:0];
			CFG_DEVICE_ID_TEXT: cfg_id_text  = val;
			default:            cfg_id_len   = val[3:0];
		endcase
	endtask

	task automatic apply_config(input logic [63:0] hdr_txt, input logic [3:0] hdr_len,
			input logic [63:0] id_txt, input logic [3:0] id_len);
		write_reg(CFG_HEADER_TEXT,      hdr_txt);
		write_reg(CFG_HEADER_LENGTH,    {60'd0, hdr_len});
		write_reg(CFG_DEVICE_ID_TEXT,   id_txt);
		write_reg(CFG_DEVICE_ID_LENGTH, {60'd0, id_len});
		cfg_valid <= 1'b0;
	endtask

	// Half printable characters, half raw bits
	function automatic logic [63:0] rand_text();
		logic [63:0] t;
		if ($urandom_range(1)) begin
			for (int i = 0; i < 8; i++)
				t[8 * i +: 8] = 8'($urandom_range(33, 126));
		end else begin
			t = {$urandom, $urandom};
		end
		return t;
	endfunction

	function automatic void push_word(input logic [39:0] word, input int wlen);
		for (int i = 0; i < wlen; i++)
			line_bytes.push_back(word[8 * (wlen - 1 - i) +: 8]);
	endfunction

	function automatic void push_junk(input int n);
		repeat (n)
			line_bytes.push_back(8'($urandom_range(33, 126)));
	endfunction

	// Build one random line, always closed by a terminator
	function automatic void build_line();
		int roll;
		int at;
		logic [7:0] b;
		line_bytes.delete();
		roll = $urandom_range(99);
		if (roll < 3) begin
			// overlong: keep terminators out so the buffer really fills
			repeat ($urandom_range(240, 300)) begin
				b = 8'($urandom_range(255));
				line_bytes.push_back((b == CH_LF || b == CH_CR) ? 8'h55 : b);
			end
		end else if (roll < 18) begin
			// noise over the full byte range
			repeat ($urandom_range(24))
				line_bytes.push_back(8'($urandom_range(255)));
		end else begin
			for (int i = 0; i < chars_used(cfg_hdr_len); i++)
				line_bytes.push_back(text_char(cfg_hdr_text, i));
			if ($urandom_range(11) == 0 && line_bytes.size() > 0) begin
				at = $urandom_range(line_bytes.size() - 1);
				line_bytes[at] = line_bytes[at] ^ 8'($urandom_range(1, 255));
			end
			line_bytes.push_back(CH_COMMA);
			if ($urandom_range(4) != 0) begin
				for (int i = 0; i < chars_used(cfg_id_len); i++)
					line_bytes.push_back(text_char(cfg_id_text, i));
			end else begin
				push_junk($urandom_range(9));
			end
			line_bytes.push_back(CH_COMMA);
			roll = $urandom_range(9);
			if (roll < 5)
				push_word(KW_CMD, 3);
			else if (roll < 8)
				push_word(KW_DATA, 4);
			else
				push_junk($urandom_range(5));
			// now and then lose the third comma
			if ($urandom_range(19) != 0)
				line_bytes.push_back(CH_COMMA);
			roll = $urandom_range(9);
			if (roll < 4)
				push_word(KW_START, 5);
			else if (roll < 7)
				push_word(KW_STOP, 4);
			else
				push_junk($urandom_range(8));
			if ($urandom_range(7) == 0)
				push_junk($urandom_range(1, 3));
			// broken forms: cut short, or a zero byte somewhere inside
			if ($urandom_range(14) == 0) begin
				at = $urandom_range(line_bytes.size() - 1);
				while (line_bytes.size() > at)
					void'(line_bytes.pop_back());
			end
			if ($urandom_range(14) == 0)
				line_bytes.insert($urandom_range(line_bytes.size()), CH_NUL);
		end
		line_bytes.push_back($urandom_range(1) ? CH_LF : CH_CR);
		// an extra LF after the terminator leaves a blank line behind
		if ($urandom_range(9) == 0)
			line_bytes.push_back(CH_LF);
	endfunction

	// ------------------------------------------------------------------------
	// Main sequence
	// ------------------------------------------------------------------------
	initial begin : stimulus
		int first;
		bit drained;
		mismatches    = 0;
		bytes_sent    = 0;
		hold_reqs     = 0;
		src_idle_pct  = 18;
		sink_idle_pct = 45;
		drained       = 1'b0;

		repeat (RESET_CYCLES) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// Hand-made lines under the reset register values
		foreach (probes[r]) begin
			for (int k = 0; k < probes[r].text.len(); k++)
				send_byte(probes[r].text[k], probes[r].pinned, probes[r].status);
			repeat (probes[r].fill_count)
				send_byte(probes[r].fill, probes[r].pinned, probes[r].status);
			send_byte(probes[r].term, probes[r].pinned, probes[r].status);
		end

		for (int p = 0; p < RAND_PHASES; p++) begin
			// Registers change only with the parser idle and nothing owed
			wait_drained();
			repeat (SETTLE_CYCLES) @(posedge clk);
			case (p)
				0: apply_config(HEADER_TEXT_RESET, HEADER_LEN_RESET, 64'h374E, 4'd2);
				// "$GPS", device "DEV12345"
				1: apply_config(64'h5350_4724, 4'd4, 64'h3534_3332_3156_4544, 4'd8);
				// no header at all, device "A"
				2: apply_config(64'd0, 4'd0, 64'h41, 4'd1);
				// everything at its top value; lengths clamp to eight
				3: apply_config({64{1'b1}}, 4'd15, {64{1'b1}}, 4'd15);
				// "#CMDLINE" with an oversized length, device "7"
				4: apply_config(64'h454E_494C_444D_4323, 4'd12, 64'h37, 4'd1);
				default: apply_config(rand_text(), 4'($urandom_range(15)), rand_text(),
					4'($urandom_range(15)));
			endcase

			// Receiver idles more than the sender, then the reverse, then neither
			if (p < 2) begin
				src_idle_pct  = 18;
				sink_idle_pct = 45;
			end else if (p < 4) begin
				src_idle_pct  = 45;
				sink_idle_pct = 18;
			end else begin
				src_idle_pct  = 0;
				sink_idle_pct = 0;
			end

			// Hold the result side for a long stretch while bytes keep coming
			if (p == 1 || p == 4)
				hold_reqs++;

			first = bytes_sent;
			while (bytes_sent - first < RAND_BYTES) begin
				build_line();
				foreach (line_bytes[i])
					send_byte(line_bytes[i], 1'b0, ST_START);
				// Pause the sender mid-phase until the results catch up
				if (p == 3 && !drained && bytes_sent - first > RAND_BYTES / 2) begin
					drained = 1'b1;
					wait_drained();
				end
			end
		end

		wait_drained();
		repeat (SETTLE_CYCLES) @(posedge clk);
		if (mismatches == 0)
			$display("TB_OK");
		else
			$display("TB_ERROR");
		$finish;
	end

	// Hard stop should the DUT hang
	initial begin : watchdog
		#(RUN_LIMIT_NS);
		$display("TB_ERROR");
		$finish;
	end

endmodule

[sim.f]
design/tcfp_pkg.sv
design/tcfp_classify.sv
design/text_command_frame_parser.sv
design/tcfp_checker.sv
verif/tb.sv
